FILE: design/pfms_pkg.sv
// Package for the pattern factor min-sum message block.
// Holds the request and result structs, the control and status structs,
// the controller state type and the 48-bit saturation helper. No dependencies.
`default_nettype none

package pfms_pkg;

  typedef struct packed {
    logic [5:0]         label_index;
    logic signed [31:0] msg_value;
    logic [5:0]         pattern_label;
    logic               is_target;
    logic               last_label;
    logic               last_node;
  } item_t;

  typedef struct packed {
    logic [5:0]         out_label;
    logic signed [47:0] out_value;
    logic signed [47:0] factor_value;
    logic               out_last;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic calc;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic close_factor;
    logic cnt_zero;
    logic emit_last;
  } dp_status_t;

  localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

  // Clamp a 49-bit signed sum into the 48-bit range.
  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] res;
    if (v[48] == v[47]) begin
      res = v[47:0];
    end else if (v[48]) begin
      res = S48_MIN;
    end else begin
      res = S48_MAX;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/pfms_ctrl.sv
// Controller state machine of the pattern factor min-sum message block.
// Depends on pfms_pkg for the state type and the command and status structs.
`default_nettype none

module pfms_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfms_pkg::dp_status_t status,
  output pfms_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);

  pfms_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfms_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfms_pkg::ST_IDLE: begin
        if (status.close_factor) state_nxt = pfms_pkg::ST_CALC;
      end
      pfms_pkg::ST_CALC: begin
        state_nxt = status.cnt_zero ? pfms_pkg::ST_IDLE : pfms_pkg::ST_EMIT;
      end
      pfms_pkg::ST_EMIT: begin
        if (status.emit_last) state_nxt = pfms_pkg::ST_IDLE;
      end
      default: state_nxt = pfms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.calc = 1'b0;
    cmd.emit = 1'b0;
    busy     = 1'b1;
    case (state_r)
      pfms_pkg::ST_IDLE: busy = 1'b0;
      pfms_pkg::ST_CALC: cmd.calc = 1'b1;
      pfms_pkg::ST_EMIT: cmd.emit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/pfms_dp.sv
// Datapath of the pattern factor min-sum message block: running minimum,
// saturating sums, message difference and the result register.
// Depends on pfms_pkg for the structs and the saturation helper.
`default_nettype none

module pfms_dp #(
  parameter int MAX_LABELS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire pfms_pkg::item_t     in_req,
  input  wire logic                cfg_we,
  input  wire logic signed [31:0]  cfg_data,
  input  wire pfms_pkg::ctrl_cmd_t cmd,
  output pfms_pkg::dp_status_t     status,
  output logic                     out_valid,
  output pfms_pkg::result_t        out_res
);

  localparam int CNT_W = $clog2(MAX_LABELS + 1);

  logic signed [31:0] cost_r;
  logic signed [47:0] min_sum_r, min_sum_nxt;
  logic signed [47:0] pat_sum_r, pat_sum_nxt;
  logic signed [32:0] node_min_r, node_min_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [5:0]         tpat_r, tpat_nxt;
  logic               factor_open_r, node_open_r, has_min_r, has_tgt_r;
  logic               has_min_nxt, has_tgt_nxt;

  logic               zero_all_r;
  logic signed [47:0] fval_r, diff_r;
  logic [CNT_W-1:0]   k_r;
  logic               out_valid_r;
  pfms_pkg::result_t  out_res_r;

  logic signed [47:0] ms_base, ps_base;
  logic [CNT_W-1:0]   cnt_base, cnt_t;
  logic               hm_base, ht_base, lab_ok;
  logic signed [32:0] neg;

  always_comb begin
    ms_base  = factor_open_r ? min_sum_r : '0;
    ps_base  = factor_open_r ? pat_sum_r : 48'(cost_r);
    cnt_base = factor_open_r ? cnt_r : '0;
    tpat_nxt = factor_open_r ? tpat_r : '0;
    hm_base  = node_open_r & has_min_r;
    ht_base  = node_open_r & has_tgt_r;
    lab_ok   = {1'b0, in_req.label_index} < 7'(MAX_LABELS);
    neg      = -{in_req.msg_value[31], in_req.msg_value};

    cnt_nxt      = cnt_base;
    cnt_t        = cnt_base;
    has_min_nxt  = hm_base;
    has_tgt_nxt  = ht_base;
    node_min_nxt = node_min_r;
    pat_sum_nxt  = ps_base;

    if (in_req.is_target) begin
      // The first target item of a node restarts the label count.
      has_tgt_nxt = 1'b1;
      cnt_t       = ht_base ? cnt_base : '0;
      tpat_nxt    = in_req.pattern_label;
      if (lab_ok && (cnt_t < CNT_W'(MAX_LABELS))) begin
        cnt_nxt = cnt_t + CNT_W'(1);
      end else begin
        cnt_nxt = cnt_t;
      end
    end else if (lab_ok) begin
      if (!hm_base || (neg < node_min_r)) begin
        node_min_nxt = neg;
        has_min_nxt  = 1'b1;
      end
      if (in_req.label_index == in_req.pattern_label) begin
        pat_sum_nxt = pfms_pkg::sat48({ps_base[47], ps_base} + 49'(neg));
      end
    end

    min_sum_nxt = ms_base;
    if ((in_req.last_label || in_req.last_node) && has_min_nxt) begin
      min_sum_nxt = pfms_pkg::sat48({ms_base[47], ms_base} + 49'(node_min_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r        <= '0;
      min_sum_r     <= '0;
      pat_sum_r     <= '0;
      node_min_r    <= '0;
      cnt_r         <= '0;
      tpat_r        <= '0;
      factor_open_r <= 1'b0;
      node_open_r   <= 1'b0;
      has_min_r     <= 1'b0;
      has_tgt_r     <= 1'b0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) cost_r <= cfg_data;
      if (accept) begin
        min_sum_r     <= min_sum_nxt;
        pat_sum_r     <= pat_sum_nxt;
        node_min_r    <= node_min_nxt;
        cnt_r         <= cnt_nxt;
        tpat_r        <= tpat_nxt;
        has_min_r     <= has_min_nxt;
        has_tgt_r     <= has_tgt_nxt;
        factor_open_r <= ~in_req.last_node;
        node_open_r   <= ~(in_req.last_label | in_req.last_node);
      end
      if (cmd.calc) begin
        k_r <= '0;
      end else if (cmd.emit) begin
        k_r <= k_r + CNT_W'(1);
      end
      out_valid_r <= cmd.emit;
    end
  end

  // Factor results and the message entries; payload needs no reset.
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      zero_all_r <= min_sum_r < pat_sum_r;
      fval_r     <= (min_sum_r < pat_sum_r) ? min_sum_r : pat_sum_r;
      diff_r     <= pfms_pkg::sat48({min_sum_r[47], min_sum_r} -
                                    {pat_sum_r[47], pat_sum_r});
    end
    if (cmd.emit) begin
      out_res_r.out_label    <= 6'(k_r);
      out_res_r.out_value    <= (zero_all_r || (6'(k_r) == tpat_r)) ? '0 : diff_r;
      out_res_r.factor_value <= fval_r;
      out_res_r.out_last     <= status.emit_last;
    end
  end

  assign status.close_factor = accept & in_req.last_node;
  assign status.cnt_zero     = (cnt_r == '0);
  assign status.emit_last    = ((k_r + CNT_W'(1)) == cnt_r);

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

FILE: design/pattern_factor_min_sum_message.sv
// Top level of the pattern factor min-sum message block.
// Instantiates pfms_ctrl and pfms_dp; uses pfms_pkg for the payload structs.
//
// Usage: the incoming messages of one factor are streamed as requests on
// in_req, one label value per request, node by node. A request is taken at a
// rising edge with start high and busy low. While a factor is being streamed
// busy stays low, so one request is taken in every cycle with start high:
// each costs at most one compare on the running node minimum and up to two
// saturating 48-bit adds. A request with last_node set closes the factor.
// Busy then rises: in the calc state the factor value and the message
// difference are formed, and in the emit state the entries are produced,
// one per target label. The first entry is registered onto out_res with
// out_valid in the first emit state, after the calc state, and entries follow
// in label order, one a cycle, with out_last on the final one. A factor with
// no target labels returns from the calc state straight to idle.
// The receiver cannot stall: each entry is on the result ports for one cycle.
// The pattern cost register is written through cfg_valid and cfg_data,
// always ready, and must only change between factors.
// Synchronous reset clears the cost, the sums and all open factor and node
// state, so the next request opens a fresh factor.
`default_nettype none

module pattern_factor_min_sum_message #(
  parameter int MAX_LABELS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire pfms_pkg::item_t    in_req,
  output logic                    out_valid,
  output pfms_pkg::result_t       out_res,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic signed [31:0] cfg_data
);

  pfms_pkg::ctrl_cmd_t  cmd;
  pfms_pkg::dp_status_t status;
  logic                 accept;

  // A request is taken whenever start is high and the controller is not busy closing a factor.
  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  pfms_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pfms_dp #(
    .MAX_LABELS (MAX_LABELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_req    (in_req),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

FILE: tb/sv/pattern_factor_min_sum_message_test.sv
// Self-checking testbench for pattern_factor_min_sum_message.
// Depends on pfms_pkg for the request and result structs and on the block itself;
// it predicts every message entry in its own model and checks each one as it appears.
module pattern_factor_min_sum_message_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The block is built with 16 label slots per node.
  localparam int LABEL_SLOTS = 16;
  // Cycles with no request, no entry and no register write before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Quiet cycles after the last entry before the register is rewritten or the run ends.
  localparam int SETTLE_CYCLES = 6;
  localparam longint S48_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_BOTTOM = -S48_TOP - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  pfms_pkg::item_t in_req = '0;
  logic out_valid;
  pfms_pkg::result_t out_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [31:0] cfg_data = '0;

  pattern_factor_min_sum_message #(
    .MAX_LABELS(LABEL_SLOTS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_res(out_res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial forever #10 clk = ~clk;

  // Requests waiting to be sent, and message entries predicted but not yet seen.
  pfms_pkg::item_t requests_waiting[$];
  pfms_pkg::result_t entries_due[$];
  int queued_requests = 0;
  int accepted_requests = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit sender_pauses = 1'b0;

  // Own copy of the block's state. The cost is what the register holds.
  logic signed [31:0] cost_q16 = '0;
  longint minima_total = 0;
  longint pattern_total = 0;
  longint node_low = 0;
  int target_count = 0;
  int target_pat_label = 0;
  bit in_factor = 1'b0;
  bit in_node = 1'b0;
  bit node_low_valid = 1'b0;
  bit node_seen_target = 1'b0;

  function automatic longint clamp48(input longint x);
    if (x > S48_TOP) return S48_TOP;
    if (x < S48_BOTTOM) return S48_BOTTOM;
    return x;
  endfunction

  // Advances the model by one accepted request. When the request closes the factor,
  // the target node's message is appended to entries_due, one entry per label.
  task automatic fold_request(input pfms_pkg::item_t it);
    longint value;
    longint negated;
    longint spread;
    longint factor_q16;
    bit all_zero;
    int k;
    pfms_pkg::result_t entry;
    value = longint'($signed(it.msg_value));
    // The first request after reset or after a closed factor opens a new factor.
    if (!in_factor) begin
      minima_total = 0;
      pattern_total = longint'(cost_q16);
      target_count = 0;
      target_pat_label = 0;
      in_factor = 1'b1;
    end
    if (!in_node) begin
      in_node = 1'b1;
      node_low_valid = 1'b0;
      node_seen_target = 1'b0;
    end
    if (it.is_target) begin
      // A later target node starts the label count over, so the last one wins.
      if (!node_seen_target) begin
        node_seen_target = 1'b1;
        target_count = 0;
      end
      target_pat_label = int'(it.pattern_label);
      if (int'(it.label_index) < LABEL_SLOTS && target_count < LABEL_SLOTS) target_count++;
    end else if (int'(it.label_index) < LABEL_SLOTS) begin
      negated = -value;
      if (!node_low_valid || negated < node_low) begin
        node_low = negated;
        node_low_valid = 1'b1;
      end
      if (it.label_index == it.pattern_label) pattern_total = clamp48(pattern_total + negated);
    end
    // Closing the factor closes the open node too, even without its last label flag.
    if (it.last_label || it.last_node) begin
      if (node_low_valid) minima_total = clamp48(minima_total + node_low);
      in_node = 1'b0;
    end
    if (it.last_node) begin
      all_zero = minima_total < pattern_total;
      factor_q16 = all_zero ? minima_total : pattern_total;
      spread = clamp48(minima_total - pattern_total);
      for (k = 0; k < target_count; k++) begin
        entry.out_label = k[5:0];
        entry.out_value = (all_zero || k == target_pat_label) ? 48'sd0 : spread[47:0];
        entry.factor_value = factor_q16[47:0];
        entry.out_last = (k + 1 == target_count);
        entries_due.push_back(entry);
      end
      in_factor = 1'b0;
    end
  endtask

  task automatic report_entry(input string why, input pfms_pkg::result_t want,
                              input pfms_pkg::result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("entry %s: expected label %0d value %0d factor %0d last %0b", why,
               want.out_label, want.out_value, want.factor_value, want.out_last);
      $display("  got label %0d value %0d factor %0d last %0b",
               got.out_label, got.out_value, got.factor_value, got.out_last);
    end
  endtask

  // Sender. A request is taken at an edge where start is high and busy is low. While
  // busy holds a request off, start and the request stay as they are. Pauses come in
  // bursts of random length now and then while sender_pauses is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = 0;
    end else begin
      if (start && !busy) begin
        fold_request(in_req);
        accepted_requests++;
      end
      if (!start || !busy) begin
        if (burst_left != 0) begin
          burst_left--;
          start <= 1'b0;
        end else if (requests_waiting.size() == 0) begin
          start <= 1'b0;
        end else if (sender_pauses && $urandom_range(0, 5) == 0) begin
          burst_left = $urandom_range(1, 15) - 1;
          start <= 1'b0;
        end else begin
          in_req <= requests_waiting.pop_front();
          start <= 1'b1;
        end
      end
    end
  end

  // Receiver. Each strobed entry is matched against the oldest predicted entry.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (entries_due.size() == 0) begin
        report_entry("with none due", '0, out_res);
      end else if (out_res.out_label !== entries_due[0].out_label
                   || out_res.out_value !== entries_due[0].out_value
                   || out_res.factor_value !== entries_due[0].factor_value
                   || out_res.out_last !== entries_due[0].out_last) begin
        report_entry("mismatch", entries_due.pop_front(), out_res);
      end else begin
        void'(entries_due.pop_front());
      end
    end
  end

  // Watchdog: any accepted request, entry or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1
        || (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic queue_request(input int lab, input logic [31:0] val,
                               input int pat, input bit tgt, input bit last_lab,
                               input bit last_nd);
    pfms_pkg::item_t it;
    it.label_index = 6'(lab);
    it.msg_value = val;
    it.pattern_label = 6'(pat);
    it.is_target = tgt;
    it.last_label = last_lab;
    it.last_node = last_nd;
    requests_waiting.push_back(it);
    queued_requests++;
  endtask

  // Message values: the two extremes, full-range words and values near zero.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($urandom_range(0, 131072)) - 32'd65536;
    endcase
  endfunction

  // A factor of one to six nodes. Mostly one target node with a pattern label inside
  // its range; now and then no target, a second target, a stray target bit inside a
  // node, a repeated label, labels past the slot limit, or a close without last_label.
  task automatic queue_random_factor();
    int nodes;
    int tgt_node;
    int extra_tgt;
    int n;
    int pat;
    int lab;
    int i;
    int j;
    bit last_lab;
    bit last_nd;
    bit tgt;
    bit drop_last_label;
    nodes = $urandom_range(1, 6);
    tgt_node = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, nodes - 1);
    extra_tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nodes - 1) : -1;
    drop_last_label = ($urandom_range(0, 3) == 0);
    for (i = 0; i < nodes; i++) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(2, 16);
      pat = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
      for (j = 0; j < n; j++) begin
        lab = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : j;
        last_nd = (i == nodes - 1) && (j == n - 1);
        last_lab = (j == n - 1) && !(last_nd && drop_last_label);
        tgt = (i == tgt_node || i == extra_tgt) ^ ($urandom_range(0, 19) == 0);
        queue_request(lab, pick_value(), pat, tgt, last_lab, last_nd);
      end
    end
  endtask

  // Requests with every field random, flags included.
  task automatic queue_noise(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      queue_request($urandom_range(0, 63), $urandom, $urandom_range(0, 63),
                    $urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1,
                    $urandom_range(0, 7) == 0);
    end
  endtask

  // A phase always ends on a well-formed factor, so the factor is closed afterwards.
  task automatic queue_random_phase(input int count);
    int first;
    first = queued_requests;
    while (queued_requests - first < count) begin
      if ($urandom_range(0, 6) == 0) queue_noise($urandom_range(1, 8));
      queue_random_factor();
    end
  endtask

  // Holds the sender until every queued request is taken and every entry has been
  // seen, then lets the block settle. A factor without target labels keeps the block
  // busy in its calc state with no entry to show for it.
  task automatic drain_block();
    while (accepted_requests != queued_requests || entries_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic write_pattern_cost(input logic signed [31:0] cost);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cost;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cost_q16 = cost;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests run at the reset cost of zero.
    sender_pauses = 1'b1;
    // Extremes of the value, a plain target message where every entry is zero.
    queue_request(0, 32'h7FFF_FFFF, 1, 0, 0, 0);
    queue_request(1, 32'h8000_0000, 1, 0, 0, 0);
    queue_request(2, 32'h0000_0005, 1, 0, 1, 0);
    queue_request(0, 32'h0000_0003, 2, 1, 0, 0);
    queue_request(1, 32'hFFFF_FFFF, 2, 1, 0, 0);
    queue_request(2, 32'h0000_0000, 2, 1, 0, 0);
    queue_request(3, 32'h0001_0000, 2, 1, 1, 1);
    // Labels past the slot limit, a pattern label that never appears, a target
    // pattern beyond the label count, and a close without last_label.
    queue_request(63, 32'h8000_0000, 40, 0, 0, 0);
    queue_request(16, 32'h0000_0001, 40, 0, 0, 0);
    queue_request(0, 32'hFFFF_0000, 40, 0, 1, 0);
    queue_request(0, 32'h0000_0000, 63, 1, 0, 0);
    queue_request(20, 32'h0000_0000, 63, 1, 0, 0);
    queue_request(1, 32'h0000_0000, 63, 1, 0, 1);
    // A factor with no target labels produces no entry.
    queue_request(5, 32'h0000_3039, 5, 0, 1, 1);
    // A mixed node with a repeated pattern label, then a second target node that wins.
    queue_request(0, 32'h0000_0064, 0, 1, 0, 0);
    queue_request(1, 32'h0000_0100, 1, 0, 0, 0);
    queue_request(1, 32'h0000_0100, 1, 0, 1, 0);
    queue_request(0, 32'h0000_0000, 1, 1, 0, 0);
    queue_request(1, 32'h0000_0000, 1, 1, 0, 0);
    queue_request(2, 32'h0000_0000, 1, 1, 1, 1);
    drain_block();

    // Random phases, one per cost setting, extremes included. The sender is drained
    // before each write so that the cost only changes between factors.
    write_pattern_cost(32'sh8000_0000);
    queue_random_phase(80);
    drain_block();

    write_pattern_cost(32'sh7FFF_FFFF);
    queue_random_phase(80);
    drain_block();

    sender_pauses = 1'b0;
    write_pattern_cost($signed(32'h8000_0000 | $urandom));
    queue_random_phase(80);
    drain_block();

    sender_pauses = 1'b1;
    write_pattern_cost($signed($urandom));
    queue_random_phase(80);
    drain_block();

    write_pattern_cost(32'sh0);
    queue_random_phase(80);
    drain_block();

    // Last part: no pauses and a final random stretch.
    sender_pauses = 1'b0;
    write_pattern_cost($signed(32'h8000_0000 | $urandom));
    queue_random_phase(60);
    drain_block();

    if (mismatches == 0 && entries_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
